@@ hdl/sfr_pkg.sv @@
// Shared types and constants for the streaming find-and-replace core.
// Used by sfr_step_logic, sfr_emit_buffer and substring_find_replace_core.
// No dependencies.
package sfr_pkg;

    // Parameter defaults
    localparam int MAX_PATTERN_BYTES_DEF = 8;
    localparam int MAX_REPLACE_BYTES_DEF = 8;
    localparam int COUNT_BITS_DEF        = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_REPLACE_BYTES  = 2'd2,
        REG_REPLACE_LENGTH = 2'd3
    } t_reg_idx;

    // Configuration as seen by the match logic
    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
    } t_cfg;

    // Per-burst control travelling from the match logic to the emit buffer
    typedef struct packed {
        logic        end_of_string;  // burst closes the string
        logic        empty_marker;   // single result without a byte
        logic [15:0] count16;        // match count, zero unless end_of_string
    } t_burst_flags;

endpackage

@@ hdl/substring_find_replace_core.sv @@
// Streaming find-and-replace core: configuration registers, match window
// state and the output burst path. Depends on sfr_pkg, sfr_step_logic and
// sfr_emit_buffer.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------
//  source   | in        | i_src_valid / o_src_ready    | i_source_byte, i_is_final
//  result   | out       | o_res_valid / i_res_ready    | o_out_byte, o_byte_valid,
//           |           |                              | o_end_of_string, o_replaced_count
//  config   | in        | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// An item that releases at most one result is taken every cycle unless the result
// side stalls. An item that releases n results (replacement or window flush, n up
// to the longer of the two maxima) holds the source side until the burst buffer,
// which drains one byte per cycle into the registered output stage unless the result
// side stalls, hands on its last byte. Reset is synchronous and clears the window, the count and the
// configuration (pattern length to 1). A stalled result side fills the output stage first, then the buffer.
module substring_find_replace_core
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    parameter int MAX_REPLACE_BYTES = MAX_REPLACE_BYTES_DEF,
    parameter int COUNT_BITS        = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // source items
    input  logic        i_src_valid,
    output logic        o_src_ready,
    input  logic [7:0]  i_source_byte,
    input  logic        i_is_final,
    // result items
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_end_of_string,
    output logic [15:0] o_replaced_count
);

    localparam int P  = MAX_PATTERN_BYTES;
    localparam int R  = MAX_REPLACE_BYTES;
    localparam int B  = (P > R) ? P : R;
    localparam int FW = $clog2(P + 1);
    localparam int BW = $clog2(B + 1);

    logic [63:0]           r_pattern_bytes;
    logic [3:0]            r_pattern_length;
    logic [63:0]           r_replace_bytes;
    logic [3:0]            r_replace_length;
    logic [7:0]            r_win [P];
    logic [FW-1:0]         r_fill;
    logic [COUNT_BITS-1:0] r_count;

    t_cfg                  cfg;
    logic [7:0]            n_win [P];
    logic [FW-1:0]         n_fill;
    logic [COUNT_BITS-1:0] n_count;
    logic [7:0]            burst_bytes [B];
    logic [BW-1:0]         burst_n;
    t_burst_flags          burst_flags;
    logic                  can_load;
    logic                  accept;

    assign o_src_ready = can_load;
    assign accept      = i_src_valid && can_load;

    assign cfg.pattern_bytes      = r_pattern_bytes;
    assign cfg.pattern_length     = r_pattern_length;
    assign cfg.replacement_bytes  = r_replace_bytes;
    assign cfg.replacement_length = r_replace_length;

    // Configuration registers and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= 64'd0;
            r_pattern_length <= 4'd1;
            r_replace_bytes  <= 64'd0;
            r_replace_length <= 4'd0;
            r_fill           <= '0;
            r_count          <= '0;
        end else begin
            if (accept) begin
                r_fill  <= n_fill;
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_PATTERN_BYTES: begin
                        r_pattern_bytes <= i_cfg_data;
                        r_fill          <= '0;
                    end
                    REG_PATTERN_LENGTH: begin
                        r_pattern_length <= i_cfg_data[3:0];
                        r_fill           <= '0;
                    end
                    REG_REPLACE_BYTES: begin
                        r_replace_bytes <= i_cfg_data;
                    end
                    REG_REPLACE_LENGTH: begin
                        r_replace_length <= i_cfg_data[3:0];
                    end
                    default: begin
                        r_replace_length <= r_replace_length;
                    end
                endcase
            end
        end
    end

    // Window bytes, only meaningful below r_fill
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

    sfr_step_logic #(
        .MAX_PATTERN_BYTES (P),
        .MAX_REPLACE_BYTES (R),
        .COUNT_BITS        (COUNT_BITS)
    ) u_step (
        .i_cfg         (cfg),
        .i_win         (r_win),
        .i_fill        (r_fill),
        .i_count       (r_count),
        .i_source_byte (i_source_byte),
        .i_is_final    (i_is_final),
        .o_win         (n_win),
        .o_fill        (n_fill),
        .o_count       (n_count),
        .o_bytes       (burst_bytes),
        .o_n           (burst_n),
        .o_flags       (burst_flags)
    );

    sfr_emit_buffer #(
        .BURST_BYTES (B)
    ) u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (accept),
        .i_bytes          (burst_bytes),
        .i_n              (burst_n),
        .i_flags          (burst_flags),
        .o_can_load       (can_load),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_end_of_string  (o_end_of_string),
        .o_replaced_count (o_replaced_count)
    );

endmodule

@@ hdl/sfr_step_logic.sv @@
// Combinational step for one source byte: window update, match test and
// the burst of result bytes the byte releases. Depends on sfr_pkg.
module sfr_step_logic
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    parameter int MAX_REPLACE_BYTES = MAX_REPLACE_BYTES_DEF,
    parameter int COUNT_BITS        = COUNT_BITS_DEF
) (
    input  t_cfg                                     i_cfg,
    input  logic [7:0]                               i_win [MAX_PATTERN_BYTES],
    input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]   i_fill,
    input  logic [COUNT_BITS-1:0]                    i_count,
    input  logic [7:0]                               i_source_byte,
    input  logic                                     i_is_final,
    output logic [7:0]                               o_win [MAX_PATTERN_BYTES],
    output logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]   o_fill,
    output logic [COUNT_BITS-1:0]                    o_count,
    output logic [7:0]                               o_bytes [(MAX_PATTERN_BYTES > MAX_REPLACE_BYTES)
                                                              ? MAX_PATTERN_BYTES : MAX_REPLACE_BYTES],
    output logic [$clog2(((MAX_PATTERN_BYTES > MAX_REPLACE_BYTES)
                          ? MAX_PATTERN_BYTES : MAX_REPLACE_BYTES) + 1)-1:0] o_n,
    output t_burst_flags                             o_flags
);

    localparam int P  = MAX_PATTERN_BYTES;
    localparam int R  = MAX_REPLACE_BYTES;
    localparam int B  = (P > R) ? P : R;
    localparam int FW = $clog2(P + 1);
    localparam int BW = $clog2(B + 1);

    logic [FW-1:0]         plen;
    logic [BW-1:0]         rlen;
    logic [7:0]            pat  [P];
    logic [7:0]            rep  [R];
    logic [7:0]            app  [P];
    logic [FW-1:0]         fill_app;
    logic [P:0]            ok;
    logic [FW-1:0]         sel_k;
    logic                  hit;
    logic [COUNT_BITS-1:0] count_next;
    logic [31:0]           count_wide;
    logic [BW-1:0]         n_raw;

    // Effective lengths, out-of-range values clamped
    always_comb begin
        if (i_cfg.pattern_length == 4'd0) begin
            plen = FW'(1);
        end else if (i_cfg.pattern_length > 4'(P)) begin
            plen = FW'(P);
        end else begin
            plen = FW'(i_cfg.pattern_length);
        end
        if (i_cfg.replacement_length > 4'(R)) begin
            rlen = BW'(R);
        end else begin
            rlen = BW'(i_cfg.replacement_length);
        end
    end

    // Byte lanes of the configured strings
    always_comb begin
        for (int j = 0; j < P; j++) begin
            pat[j] = i_cfg.pattern_bytes[8*j +: 8];
        end
        for (int j = 0; j < R; j++) begin
            rep[j] = i_cfg.replacement_bytes[8*j +: 8];
        end
    end

    // Window with the new byte appended
    always_comb begin
        for (int j = 0; j < P; j++) begin
            app[j] = (FW'(j) == i_fill) ? i_source_byte : i_win[j];
        end
        fill_app = i_fill + FW'(1);
    end

    // ok[k]: window without its k oldest bytes is a prefix of the pattern
    always_comb begin
        for (int k = 0; k <= P; k++) begin
            ok[k] = (FW'(k) <= fill_app) &&
                    ({1'b0, fill_app} <= ({1'b0, plen} + (FW+1)'(k)));
            for (int j = 0; j < P; j++) begin
                if (k + j < P) begin
                    if ((FW'(k + j) < fill_app) && (app[k+j] != pat[j])) begin
                        ok[k] = 1'b0;
                    end
                end
            end
        end
    end

    // Fewest released bytes that leave a prefix (leftmost search)
    always_comb begin
        sel_k = fill_app;
        for (int k = P; k >= 0; k--) begin
            if (ok[k]) begin
                sel_k = FW'(k);
            end
        end
        hit = ok[0] && (fill_app == plen);
    end

    // Remaining window after release
    always_comb begin
        for (int j = 0; j < P; j++) begin
            o_win[j] = app[j];
        end
        for (int k = 1; k < P; k++) begin
            if (sel_k == FW'(k)) begin
                for (int j = 0; j < P; j++) begin
                    o_win[j] = (k + j < P) ? app[(k + j) % P] : 8'd0;
                end
            end
        end
        o_fill = (hit || i_is_final) ? '0 : (fill_app - sel_k);
    end

    // Match count, saturating
    always_comb begin
        count_next = i_count;
        if (hit && (i_count != {COUNT_BITS{1'b1}})) begin
            count_next = i_count + COUNT_BITS'(1);
        end
        o_count    = i_is_final ? '0 : count_next;
        count_wide = 32'(count_next);
    end

    // Burst: replacement on a hit, otherwise released (or flushed) bytes
    always_comb begin
        if (hit) begin
            n_raw = rlen;
        end else if (i_is_final) begin
            n_raw = BW'(fill_app);
        end else begin
            n_raw = BW'(sel_k);
        end
        for (int j = 0; j < B; j++) begin
            if (hit) begin
                o_bytes[j] = (j < R) ? rep[j % R] : 8'd0;
            end else begin
                o_bytes[j] = (j < P) ? app[j % P] : 8'd0;
            end
        end
        o_flags.end_of_string = i_is_final;
        o_flags.empty_marker  = 1'b0;
        o_flags.count16       = i_is_final ? count_wide[15:0] : 16'd0;
        o_n                   = n_raw;
        // nothing to show on the last byte: one result without a byte
        if (i_is_final && (n_raw == '0)) begin
            o_n                  = BW'(1);
            o_bytes[0]           = 8'd0;
            o_flags.empty_marker = 1'b1;
        end
    end

endmodule

@@ hdl/sfr_emit_buffer.sv @@
// Burst buffer that drains one result per cycle, while the output stage is free or being
// taken, into a registered output stage with valid/ready. Depends on sfr_pkg.
module sfr_emit_buffer
    import sfr_pkg::*;
#(
    parameter int BURST_BYTES = MAX_PATTERN_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [7:0]                     i_bytes [BURST_BYTES],
    input  logic [$clog2(BURST_BYTES+1)-1:0] i_n,
    input  t_burst_flags                   i_flags,
    output logic                           o_can_load,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_byte_valid,
    output logic                           o_end_of_string,
    output logic [15:0]                    o_replaced_count
);

    localparam int BW = $clog2(BURST_BYTES + 1);

    logic [7:0]    r_bytes [BURST_BYTES];
    logic [BW-1:0] r_left;
    t_burst_flags  r_flags;
    logic          r_ov;
    logic [7:0]    r_ob;
    logic          r_bv;
    logic          r_eos;
    logic [15:0]   r_cnt;
    logic          pop;
    logic          head_last;

    // Move the head into the output stage when it is free or being taken
    assign head_last  = (r_left == BW'(1));
    assign pop        = (r_left != '0) && (!r_ov || i_res_ready);
    assign o_can_load = (r_left == '0) || (head_last && pop);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_load) begin
                r_left <= i_n;
            end else if (pop) begin
                r_left <= r_left - BW'(1);
            end
            if (pop) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Burst payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_bytes;
            r_flags <= i_flags;
        end else if (pop) begin
            for (int j = 0; j < BURST_BYTES - 1; j++) begin
                r_bytes[j] <= r_bytes[j+1];
            end
        end
    end

    // Output stage payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ob  <= r_bytes[0];
            r_bv  <= !r_flags.empty_marker;
            r_eos <= r_flags.end_of_string && head_last;
            r_cnt <= (r_flags.end_of_string && head_last) ? r_flags.count16 : 16'd0;
        end
    end

    assign o_res_valid      = r_ov;
    assign o_out_byte       = r_ob;
    assign o_byte_valid     = r_bv;
    assign o_end_of_string  = r_eos;
    assign o_replaced_count = r_cnt;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for substring_find_replace_core: random and directed source strings,
// predicted rewrite checked item by item on the result channel.
// Depends on sfr_pkg and substring_find_replace_core.
`timescale 1ns / 1ps

module testbench;
    import sfr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 24;
    localparam int unsigned HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } source_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        end_of_string;
        logic [15:0] replaced_count;
    } rewritten_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    always #2 clk = ~clk;

    // Block inputs
    logic        cfg_we    = 1'b0;
    t_reg_idx    cfg_index = REG_PATTERN_BYTES;
    logic [63:0] cfg_data  = 64'd0;
    logic        src_valid = 1'b0;
    logic [7:0]  src_byte  = 8'd0;
    logic        src_last  = 1'b0;
    logic        res_ready = 1'b0;

    // Block outputs
    logic        o_src_ready;
    logic        o_res_valid;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_end_of_string;
    logic [15:0] o_replaced_count;

    substring_find_replace_core dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_src_valid      (src_valid),
        .o_src_ready      (o_src_ready),
        .i_source_byte    (src_byte),
        .i_is_final       (src_last),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (res_ready),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_end_of_string  (o_end_of_string),
        .o_replaced_count (o_replaced_count)
    );

    // Bench state
    source_item_t pending_src [$];
    rewritten_t   rewritten_q [$];
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  hold_req       = 0;
    int unsigned  hold_ack       = 0;
    int unsigned  hold_left      = 0;
    int unsigned  faults         = 0;
    int unsigned  quiet_cycles   = 0;
    source_item_t next_item;
    rewritten_t   want;

    // Rewrite predictor: its own copy of the rule and the match window
    logic [63:0] rule_pattern = 64'd0;
    logic [3:0]  rule_pat_len = 4'd1;
    logic [63:0] rule_replace = 64'd0;
    logic [3:0]  rule_rep_len = 4'd0;
    logic [7:0]  held [8];
    int unsigned win_fill = 0;
    logic [15:0] hits     = 16'd0;

    function automatic int unsigned eff_pat_len();
        if (rule_pat_len == 4'd0) return 1;
        if (rule_pat_len > MAX_PATTERN_BYTES_DEF) return MAX_PATTERN_BYTES_DEF;
        return 32'(rule_pat_len);
    endfunction

    // Work out the results one accepted source byte releases
    task automatic rewrite_byte(input logic [7:0] value, input logic last);
        rewritten_t  burst [16];
        int unsigned plen, rlen, n, i;
        logic        is_prefix;
        plen = eff_pat_len();
        rlen = (rule_rep_len > MAX_REPLACE_BYTES_DEF) ? MAX_REPLACE_BYTES_DEF
                                                      : 32'(rule_rep_len);
        n = 0;
        if (win_fill > 7) win_fill = 7;
        held[win_fill] = value;
        win_fill++;
        // release the oldest byte until the window is a pattern prefix again
        forever begin
            is_prefix = (win_fill <= plen);
            for (i = 0; i < win_fill; i++)
                if (held[i] != rule_pattern[8*i +: 8]) is_prefix = 1'b0;
            if (is_prefix) begin
                if (win_fill == plen) begin
                    for (i = 0; i < rlen; i++) begin
                        burst[n] = rewritten_t'{rule_replace[8*i +: 8], 1'b1, 1'b0, 16'd0};
                        n++;
                    end
                    win_fill = 0;
                    if (hits != 16'hFFFF) hits++;
                end
                break;
            end
            burst[n] = rewritten_t'{held[0], 1'b1, 1'b0, 16'd0};
            n++;
            for (i = 0; i < 7; i++) held[i] = held[i + 1];
            held[7] = 8'd0;
            win_fill--;
        end
        // last byte: flush the window, close the string with the count
        if (last) begin
            for (i = 0; i < win_fill; i++) begin
                burst[n] = rewritten_t'{held[i], 1'b1, 1'b0, 16'd0};
                n++;
            end
            if (n == 0) begin
                burst[0] = rewritten_t'{8'd0, 1'b0, 1'b0, 16'd0};
                n = 1;
            end
            burst[n - 1].end_of_string  = 1'b1;
            burst[n - 1].replaced_count = hits;
            win_fill = 0;
            hits = 16'd0;
            for (i = 0; i < 8; i++) held[i] = 8'd0;
        end
        for (i = 0; i < n; i++) rewritten_q.push_back(burst[i]);
    endtask

    // Register write; only called while nothing is in flight
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PATTERN_BYTES: begin
                rule_pattern = val;
                win_fill = 0;
            end
            REG_PATTERN_LENGTH: begin
                rule_pat_len = val[3:0];
                win_fill = 0;
            end
            REG_REPLACE_BYTES:  rule_replace = val;
            REG_REPLACE_LENGTH: rule_rep_len = val[3:0];
            default: begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] value, input logic last);
        pending_src.push_back(source_item_t'{value, last});
    endtask

    // Wait for the sender to run dry and every result to arrive, then let the core settle
    task automatic wait_idle();
        while (pending_src.size() != 0 || src_valid || rewritten_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random rule: pattern bytes lean on a two-letter alphabet so partial matches are common
    task automatic pick_random_rule();
        logic [63:0] pat;
        logic [3:0]  plen, rlen;
        int unsigned i, roll;
        for (i = 0; i < 8; i++)
            pat[8*i +: 8] = ($urandom_range(9) < 6) ?
                            ($urandom_range(1) ? 8'h61 : 8'h62) : 8'($urandom);
        roll = $urandom_range(99);
        if (roll < 65)      plen = 4'($urandom_range(1, 4));
        else if (roll < 90) plen = 4'($urandom_range(5, 8));
        else                plen = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
        rlen = ($urandom_range(9) != 0) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_PATTERN_LENGTH, ({$urandom, $urandom} & ~64'hF) | 64'(plen));
        write_reg(REG_REPLACE_BYTES, {$urandom, $urandom});
        write_reg(REG_REPLACE_LENGTH, ({$urandom, $urandom} & ~64'hF) | 64'(rlen));
    endtask

    // Strings built from whole patterns, pattern prefixes, pattern letters and noise
    task automatic queue_random_strings(input int unsigned target);
        logic [7:0]  text [$];
        int unsigned sent, len, plen, piece, cut, j;
        sent = 0;
        plen = eff_pat_len();
        while (sent < target) begin
            text.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            while (text.size() < len) begin
                piece = $urandom_range(99);
                if (piece < 40)      cut = plen;
                else if (piece < 65) cut = $urandom_range(1, plen);
                else                 cut = 0;
                for (j = 0; j < cut; j++) text.push_back(rule_pattern[8*j +: 8]);
                if (piece >= 65 && piece < 85)
                    text.push_back(rule_pattern[8*$urandom_range(0, plen - 1) +: 8]);
                else if (piece >= 85)
                    text.push_back(8'($urandom));
            end
            for (j = 0; j < text.size(); j++) push_byte(text[j], j == text.size() - 1);
            sent += text.size();
        end
    endtask

    // Source driver: predicts on each accepted item, then offers the next one
    always @(posedge clk) begin
        if (!rst_n) begin
            src_valid <= 1'b0;
        end else begin
            if (src_valid && o_src_ready) rewrite_byte(src_byte, src_last);
            if (!src_valid || o_src_ready) begin
                if (pending_src.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_src.pop_front();
                    src_valid <= 1'b1;
                    src_byte  <= next_item.value;
                    src_last  <= next_item.last;
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stalls, long hold-off on request, compare with oldest expectation
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (o_res_valid && res_ready) begin
                if (rewritten_q.size() == 0) begin
                    if (faults < 10)
                        $display("unexpected result item: byte %02h valid %0d end %0d count %0d",
                                 o_out_byte, o_byte_valid, o_end_of_string, o_replaced_count);
                    faults++;
                end else begin
                    want = rewritten_q.pop_front();
                    if (o_out_byte !== want.out_byte || o_byte_valid !== want.byte_valid ||
                        o_end_of_string !== want.end_of_string ||
                        o_replaced_count !== want.replaced_count) begin
                        if (faults < 10)
                            $display("result mismatch: expected %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                                     want.out_byte, want.byte_valid, want.end_of_string,
                                     want.replaced_count, o_out_byte, o_byte_valid,
                                     o_end_of_string, o_replaced_count);
                        faults++;
                    end
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge clk) begin
        if (!rst_n || (src_valid && o_src_ready) || (o_res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned ph, k;
        int unsigned send_mix [4];
        int unsigned recv_mix [4];
        send_mix = '{0, 73, 0, 13};
        recv_mix = '{0, 0, 73, 13};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset rule: single zero byte, deleted; last byte matching gives the empty marker
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        // Backtracking after a partial match, full-width replacement, flush on last byte
        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0062_6161);
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        write_reg(REG_REPLACE_BYTES, 64'hF0E1_D2C3_B4A5_9687);
        write_reg(REG_REPLACE_LENGTH, 64'd8);
        push_byte(8'h61, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h61, 1'b1);

        // Pattern rewritten mid-string drops the pending window
        push_byte(8'h61, 1'b0);
        push_byte(8'h61, 1'b0);
        wait_idle();
        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b1);
        push_byte(8'h61, 1'b0);
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        push_byte(8'h62, 1'b1);
        wait_idle();

        // Longest pattern (length above range), deletion, long flush
        write_reg(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PATTERN_LENGTH, 64'd15);
        write_reg(REG_REPLACE_LENGTH, 64'd0);
        for (k = 0; k < 11; k++) push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        // Zero pattern length acts as one; replacement length above range acts as eight
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        write_reg(REG_REPLACE_BYTES, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_REPLACE_LENGTH, 64'd15);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        wait_idle();

        // Random rules under each idling mix; first rule also gets a long receiver hold-off
        for (ph = 0; ph < 8; ph++) begin
            wait_idle();
            send_idle_pct  = send_mix[ph / 2];
            recv_stall_pct = recv_mix[ph / 2];
            pick_random_rule();
            if (ph == 0) begin
                write_reg(REG_REPLACE_LENGTH, 64'd8);
                hold_req++;
            end
            queue_random_strings(30);
        end

        wait_idle();
        if (faults == 0 && rewritten_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
